// File: rtl/ncp_pkg.sv
// Package for the normalized cross product block: constants, status codes and side-band type.
`default_nettype none
package ncp_pkg;

    // Scaled magnitudes are normalized so the largest lies in [2^29, 2^30)
    localparam int NORM_TOP = 30;
    localparam int VW       = NORM_TOP;
    // Sum of three squares and the integer square root built on it
    localparam int SUM_W    = 2 * VW + 2;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int SQ_W     = 64;
    localparam int NW       = SQ_STEPS;
    // Product of the two input lengths after dropping 30 bits, and times threshold
    localparam int PROD_W   = 2 * NW - NORM_TOP;
    localparam int THR_W    = 16;
    localparam int TP_W     = PROD_W + THR_W;
    localparam int EXP_W    = 10;
    // Beyond these exponents the sine compare is settled without the full compare
    localparam int SINE_E_HI = 19;
    localparam int SINE_E_LO = -4;
    localparam int EXP_BIAS  = 16;
    localparam int CMP_W     = 64;
    localparam int OUT_W     = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_PARALLEL = 2'd2
    } t_status;

    // Per-item flags and data that ride beside the arithmetic
    typedef struct packed {
        logic                      zero;
        logic                      czero;
        logic                      par;
        logic [2:0]                neg;
        logic signed [EXP_W-1:0]   expo;
        logic [2:0][VW-1:0]        vc;
    } t_side;

endpackage
`default_nettype wire

// File: rtl/normalized_cross_product.sv
// Top level: pipelined unit vector of a 3D cross product with parallel check.
// The pipe holds 41 + OUT_FRAC_BITS + 1 register stages up to the output register (56 at defaults).
// Throughput: one item per cycle unless the output stalls; the 31-step square root and
// the bit-per-stage divider are fully pipelined, so every stage takes a new item each cycle.
// The whole pipe advances when the output register is empty or being taken.
// Reset (synchronous, active low) clears all valid bits and the threshold to 0.
`default_nettype none
module normalized_cross_product #(
    parameter int COMPONENT_BITS = 16,
    parameter int OUT_FRAC_BITS  = 14
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ncp_pkg::THR_W-1:0]        i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  signed [COMPONENT_BITS-1:0] i_first_x,
    input  wire  signed [COMPONENT_BITS-1:0] i_first_y,
    input  wire  signed [COMPONENT_BITS-1:0] i_first_z,
    input  wire  signed [COMPONENT_BITS-1:0] i_second_x,
    input  wire  signed [COMPONENT_BITS-1:0] i_second_y,
    input  wire  signed [COMPONENT_BITS-1:0] i_second_z,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic signed [ncp_pkg::OUT_W-1:0] o_unit_x,
    output logic signed [ncp_pkg::OUT_W-1:0] o_unit_y,
    output logic signed [ncp_pkg::OUT_W-1:0] o_unit_z,
    output logic [1:0]                       o_status
);
    import ncp_pkg::*;

    localparam int N  = COMPONENT_BITS;
    localparam int CW = 2 * N;
    localparam int LW = $clog2(CW + 1);
    localparam int XW = CW + NORM_TOP;
    localparam int QB = OUT_FRAC_BITS + 1;
    localparam int DW = OUT_FRAC_BITS + 33;

    logic adv;
    logic [THR_W-1:0] r_thresh;

    // Config register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    logic r_ov;
    assign adv        = !r_ov || i_out_ready;
    assign o_in_ready = adv;

    // Stage 1: operands and the six cross products
    logic                r1_v;
    logic signed [N-1:0] r1_a [3];
    logic signed [N-1:0] r1_b [3];
    logic signed [CW-1:0] r1_u [3];
    logic signed [CW-1:0] r1_w [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_a[0] <= i_first_x;  r1_a[1] <= i_first_y;  r1_a[2] <= i_first_z;
            r1_b[0] <= i_second_x; r1_b[1] <= i_second_y; r1_b[2] <= i_second_z;
            r1_u[0] <= i_first_y * i_second_z;
            r1_w[0] <= i_first_z * i_second_y;
            r1_u[1] <= i_first_z * i_second_x;
            r1_w[1] <= i_first_x * i_second_z;
            r1_u[2] <= i_first_x * i_second_y;
            r1_w[2] <= i_first_y * i_second_x;
        end
    end

    // Stage 2: magnitudes of A, B and of the cross components
    logic          r2_v;
    logic [CW-1:0] r2_mag [3][3];
    t_side         r2_side;
    logic signed [CW:0] dif [3];
    logic [N-1:0]  ma [3];
    logic [N-1:0]  mb [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dif[k] = {r1_u[k][CW-1], r1_u[k]} - {r1_w[k][CW-1], r1_w[k]};
            ma[k]  = r1_a[k][N-1] ? N'(-r1_a[k]) : N'(r1_a[k]);
            mb[k]  = r1_b[k][N-1] ? N'(-r1_b[k]) : N'(r1_b[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r2_mag[0][k]   <= CW'(ma[k]);
                r2_mag[1][k]   <= CW'(mb[k]);
                r2_mag[2][k]   <= dif[k][CW] ? CW'(-dif[k]) : CW'(dif[k]);
                r2_side.neg[k] <= dif[k][CW];
            end
            r2_side.zero  <= ((ma[0] | ma[1] | ma[2]) == '0) || ((mb[0] | mb[1] | mb[2]) == '0);
            r2_side.czero <= 1'b0;
            r2_side.par   <= 1'b0;
            r2_side.expo  <= '0;
            r2_side.vc    <= '0;
        end
    end

    // Stage 3: bit length of each vector's largest component
    logic          r3_v;
    logic [CW-1:0] r3_mag [3][3];
    logic [LW-1:0] r3_len [3];
    t_side         r3_side;
    t_side         n3_side;
    logic [CW-1:0] orv [3];
    logic [LW-1:0] len [3];

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            orv[g] = r2_mag[g][0] | r2_mag[g][1] | r2_mag[g][2];
            len[g] = '0;
            for (int i = 0; i < CW; i++) begin
                if (orv[g][i]) len[g] = LW'(i + 1);
            end
        end
        n3_side       = r2_side;
        n3_side.czero = (orv[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_mag  <= r2_mag;
            r3_len  <= len;
            r3_side <= n3_side;
        end
    end

    // Stage 4: normalize magnitudes to the 30-bit window, form the sine exponent
    logic          r4_v;
    logic [VW-1:0] r4_vec [3][3];
    t_side         r4_side;
    t_side         n4_side;
    logic [XW-1:0] shx [3][3];
    logic [7:0]    lx  [3];

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            lx[g] = 8'(r3_len[g]);
            for (int k = 0; k < 3; k++) begin
                if (lx[g] >= 8'(NORM_TOP)) begin
                    shx[g][k] = XW'(r3_mag[g][k]) >> (lx[g] - 8'(NORM_TOP));
                end else begin
                    shx[g][k] = XW'(r3_mag[g][k]) << (8'(NORM_TOP) - lx[g]);
                end
            end
        end
        n4_side       = r3_side;
        n4_side.vc[0] = shx[2][0][VW-1:0];
        n4_side.vc[1] = shx[2][1][VW-1:0];
        n4_side.vc[2] = shx[2][2][VW-1:0];
        n4_side.expo  = $signed(EXP_W'(lx[2])) - $signed(EXP_W'(lx[0]))
                        - $signed(EXP_W'(lx[1])) + EXP_W'(EXP_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_vec[g][k] <= shx[g][k][VW-1:0];
                end
            end
            r4_side <= n4_side;
        end
    end

    // Stage 5: squares
    logic               r5_v;
    logic [2*VW-1:0]    r5_sq [3][3];
    t_side              r5_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_sq[g][k] <= r4_vec[g][k] * r4_vec[g][k];
                end
            end
            r5_side <= r4_side;
        end
    end

    // Stage 6 and square root steps: one result bit per stage
    logic            r_sqv  [0:SQ_STEPS];
    logic [SQ_W-1:0] r_rem  [0:SQ_STEPS][3];
    logic [SQ_W-1:0] r_root [0:SQ_STEPS][3];
    t_side           r_sq_side [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                r_rem[0][g]  <= SQ_W'(SUM_W'(r5_sq[g][0]) + SUM_W'(r5_sq[g][1])
                                      + SUM_W'(r5_sq[g][2]));
                r_root[0][g] <= '0;
            end
            r_sq_side[0] <= r5_side;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int g = 0; g < 3; g++) begin
                    if (r_rem[k][g] >= r_root[k][g] + SQ_BIT) begin
                        r_rem[k+1][g]  <= r_rem[k][g] - (r_root[k][g] + SQ_BIT);
                        r_root[k+1][g] <= (r_root[k][g] >> 1) + SQ_BIT;
                    end else begin
                        r_rem[k+1][g]  <= r_rem[k][g];
                        r_root[k+1][g] <= r_root[k][g] >> 1;
                    end
                end
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqv[k+1] <= 1'b0;
            end else if (adv) begin
                r_sqv[k+1] <= r_sqv[k];
            end
        end
    end

    // Q1: product of the input lengths
    logic              rq1_v;
    logic [PROD_W-1:0] rq1_prod;
    logic [NW-1:0]     rq1_nc;
    t_side             rq1_side;
    logic [2*NW-1:0]   pfull;

    assign pfull = r_root[SQ_STEPS][0][NW-1:0] * r_root[SQ_STEPS][1][NW-1:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rq1_prod <= PROD_W'(pfull >> NORM_TOP);
            rq1_nc   <= r_root[SQ_STEPS][2][NW-1:0];
            rq1_side <= r_sq_side[SQ_STEPS];
        end
    end

    // Q2: threshold times product
    logic            rq2_v;
    logic [TP_W-1:0] rq2_tp;
    logic [NW-1:0]   rq2_nc;
    t_side           rq2_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rq2_tp   <= TP_W'(rq1_prod) * TP_W'(r_thresh);
            rq2_nc   <= rq1_nc;
            rq2_side <= rq1_side;
        end
    end

    // Q3: sine compare nc * 2^e <= T * prod, and divider setup
    logic                    n_par;
    logic signed [EXP_W-1:0] nexp;
    t_side                   n_dv_side;

    always_comb begin
        nexp = -rq2_side.expo;
        if (rq2_side.expo >= EXP_W'(SINE_E_HI)) begin
            n_par = 1'b0;
        end else if (rq2_side.expo <= EXP_W'(SINE_E_LO)) begin
            n_par = (rq2_tp != '0);
        end else if (rq2_side.expo >= 0) begin
            n_par = (CMP_W'(rq2_nc) << rq2_side.expo[4:0]) <= CMP_W'(rq2_tp);
        end else begin
            n_par = CMP_W'(rq2_nc) <= (CMP_W'(rq2_tp) << nexp[1:0]);
        end
        n_dv_side     = rq2_side;
        n_dv_side.par = n_par;
    end

    logic          r_dvv     [0:QB];
    logic [DW-1:0] r_dv_rem  [0:QB][3];
    logic [QB-1:0] r_dv_q    [0:QB][3];
    logic [NW-1:0] r_dv_nc   [0:QB];
    t_side         r_dv_side [0:QB];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                r_dv_rem[0][g] <= (DW'(rq2_side.vc[g]) << (OUT_FRAC_BITS + 1)) + DW'(rq2_nc);
                r_dv_q[0][g]   <= '0;
            end
            r_dv_nc[0]   <= rq2_nc;
            r_dv_side[0] <= n_dv_side;
        end
    end

    // Restoring divider by 2*nc, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int QI = QB - 1 - j;
        logic [DW-1:0] dsh;
        assign dsh = DW'(r_dv_nc[j]) << (QI + 1);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int g = 0; g < 3; g++) begin
                    if (r_dv_rem[j][g] >= dsh) begin
                        r_dv_rem[j+1][g]   <= r_dv_rem[j][g] - dsh;
                        r_dv_q[j+1][g]     <= r_dv_q[j][g] | (QB'(1) << QI);
                    end else begin
                        r_dv_rem[j+1][g]   <= r_dv_rem[j][g];
                        r_dv_q[j+1][g]     <= r_dv_q[j][g];
                    end
                end
                r_dv_nc[j+1]   <= r_dv_nc[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[j+1] <= 1'b0;
            end else if (adv) begin
                r_dvv[j+1] <= r_dvv[j];
            end
        end
    end

    // Output stage: status, sign and saturation
    logic signed [OUT_W-1:0] r_u [3];
    t_status                 r_st;
    logic signed [OUT_W-1:0] uval [3];
    logic [31:0]             qx [3];
    t_status                 st;
    t_side                   fs;

    always_comb begin
        fs = r_dv_side[QB];
        if (fs.zero) begin
            st = ST_ZERO;
        end else if (fs.czero || fs.par) begin
            st = ST_PARALLEL;
        end else begin
            st = ST_OK;
        end
        for (int g = 0; g < 3; g++) begin
            qx[g] = 32'(r_dv_q[QB][g]);
            if (st != ST_OK) begin
                uval[g] = '0;
            end else if (fs.neg[g]) begin
                uval[g] = (qx[g] > 32'd32768) ? -16'sd32768 : OUT_W'(-qx[g]);
            end else begin
                uval[g] = (qx[g] > 32'd32767) ? 16'sd32767 : OUT_W'(qx[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u[0] <= uval[0];
            r_u[1] <= uval[1];
            r_u[2] <= uval[2];
            r_st   <= st;
        end
    end

    // Valid bits of the fixed stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r5_v     <= 1'b0;
            r_sqv[0] <= 1'b0;
            rq1_v    <= 1'b0;
            rq2_v    <= 1'b0;
            r_dvv[0] <= 1'b0;
            r_ov     <= 1'b0;
        end else if (adv) begin
            r1_v     <= i_in_valid;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r5_v     <= r4_v;
            r_sqv[0] <= r5_v;
            rq1_v    <= r_sqv[SQ_STEPS];
            rq2_v    <= rq1_v;
            r_dvv[0] <= rq2_v;
            r_ov     <= r_dvv[QB];
        end
    end

    assign o_out_valid = r_ov;
    assign o_unit_x    = r_u[0];
    assign o_unit_y    = r_u[1];
    assign o_unit_z    = r_u[2];
    assign o_status    = r_st;

    // Checks
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            (o_unit_x == 0) && (o_unit_y == 0) && (o_unit_z == 0))
        else $error("failed item carries nonzero components");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK) |->
            (o_unit_x != 0) || (o_unit_y != 0) || (o_unit_z != 0))
        else $error("unit vector is all zero");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("pipe stalls with empty output register");

endmodule
`default_nettype wire
